### src/utli_pkg.sv
// Shared types and constants for the uniform table linear interpolation unit.
`timescale 1ns / 1ps

package utli_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int INDEX_W     = 8;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 9;
  localparam int FRAC_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int STATUS_W    = 2;

  localparam logic [VALUE_W-1:0] ORIGIN_RESET = 32'h0000_0000;
  localparam logic [VALUE_W-1:0] RECIP_RESET  = 32'h0001_0000;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = 9'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_ORIGIN     = 2'd0,
    CFG_STEP_RECIPROCAL = 2'd1,
    CFG_ENTRY_COUNT     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INTERP     = 2'd0,
    ST_CLAMP_LOW  = 2'd1,
    ST_CLAMP_HIGH = 2'd2,
    ST_SINGLE     = 2'd3
  } status_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
  } table_req_t;

endpackage

### src/uniform_table_linear_interp_unit.sv
// Uniform-grid linear interpolation unit. Takes one transaction per clock (a table write or
// a query) while the output is not stalled and returns one result per query; writes give
// no result. After the input register come the origin subtract, the 32x32 step multiply,
// the registered dual-port table read, the 33x17 slope multiply and the output register,
// one stage each. Writes pass through the same stages and update the table at the read
// stage, so every query sees exactly the writes accepted before it. When the output is
// stalled the whole pipeline holds. Table entries come up undefined; read only entries that
// were written.
`timescale 1ns / 1ps

module uniform_table_linear_interp_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [utli_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [utli_pkg::VALUE_W-1:0]         cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [utli_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [utli_pkg::VALUE_W-1:0]  entry_value,
  input  logic signed [utli_pkg::VALUE_W-1:0]  query_x,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [utli_pkg::VALUE_W-1:0]  result_value,
  output logic [utli_pkg::STATUS_W-1:0]        clamp_status
);

  localparam int VW     = utli_pkg::VALUE_W;
  localparam int AW     = utli_pkg::ADDR_W;
  localparam int IW     = utli_pkg::INDEX_W;
  localparam int FW     = utli_pkg::FRAC_W;
  localparam int CW     = utli_pkg::COUNT_W;
  localparam int DIFF_W = VW + 1;
  localparam int PROD_W = DIFF_W + FW + 1;

  // configuration registers
  logic signed [VW-1:0]              grid_origin;
  logic [VW-1:0]                     step_reciprocal;
  logic [utli_pkg::COUNT_W-1:0]      entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_origin     <= utli_pkg::ORIGIN_RESET;
      step_reciprocal <= utli_pkg::RECIP_RESET;
      entry_count     <= utli_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        utli_pkg::CFG_GRID_ORIGIN:     grid_origin     <= cfg_data;
        utli_pkg::CFG_STEP_RECIPROCAL: step_reciprocal <= cfg_data;
        utli_pkg::CFG_ENTRY_COUNT:     entry_count     <= cfg_data[utli_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // stage 1: captured transaction
  logic                 s1_valid, s1_query;
  logic [IW-1:0]        s1_idx;
  logic [VW-1:0]        s1_value;
  logic signed [VW-1:0] s1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_query <= (action == utli_pkg::ACT_QUERY);
      s1_idx   <= entry_index;
      s1_value <= entry_value;
      s1_x     <= query_x;
    end
  end

  // stage 2: offset from origin
  logic signed [DIFF_W-1:0] x_off;
  logic                     x_off_neg;
  assign x_off     = {s1_x[VW-1], s1_x} - {grid_origin[VW-1], grid_origin};
  assign x_off_neg = x_off[DIFF_W-1];

  logic           s2_valid, s2_query, s2_low;
  logic [IW-1:0]  s2_idx;
  logic [VW-1:0]  s2_value, s2_ud;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_query <= s1_query;
      s2_idx   <= s1_idx;
      s2_value <= s1_value;
      s2_low   <= x_off_neg && (step_reciprocal != '0);
      s2_ud    <= x_off_neg ? '0 : x_off[VW-1:0];
    end
  end

  // stage 3: scaled position, Q32.32
  logic [2*VW-1:0] pos_next;
  assign pos_next = s2_ud * step_reciprocal;

  logic            s3_valid, s3_query, s3_low;
  logic [IW-1:0]   s3_idx;
  logic [VW-1:0]   s3_value;
  logic [2*VW-1:0] s3_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_query <= s2_query;
      s3_idx   <= s2_idx;
      s3_value <= s2_value;
      s3_low   <= s2_low;
      s3_pos   <= pos_next;
    end
  end

  // segment select and table access
  logic [VW-1:0]         seg;
  logic [FW-1:0]         frac;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         addr_a;
  utli_pkg::status_t     status_next;
  utli_pkg::table_req_t  req;

  assign seg  = s3_pos[2*VW-1:VW];
  assign frac = s3_pos[VW-1:VW-FW];

  always_comb begin
    if (entry_count == '0) begin
      last_idx = '0;
    end else if (32'(entry_count) > utli_pkg::TABLE_DEPTH) begin
      last_idx = AW'(utli_pkg::TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(entry_count - CW'(1));
    end
  end

  always_comb begin
    if (last_idx == '0) begin
      status_next = utli_pkg::ST_SINGLE;
      addr_a      = '0;
    end else if (s3_low) begin
      status_next = utli_pkg::ST_CLAMP_LOW;
      addr_a      = '0;
    end else if (seg >= VW'(last_idx)) begin
      status_next = utli_pkg::ST_CLAMP_HIGH;
      addr_a      = last_idx;
    end else begin
      status_next = utli_pkg::ST_INTERP;
      addr_a      = seg[AW-1:0];
    end
  end

  // clamped queries read one entry on both ports, so the slope is zero
  always_comb begin
    req.wr_en     = advance && s3_valid && !s3_query && (32'(s3_idx) < utli_pkg::TABLE_DEPTH);
    req.wr_addr   = AW'(s3_idx);
    req.wr_data   = s3_value;
    req.rd_en     = advance && s3_valid && s3_query;
    req.rd_addr_a = addr_a;
    req.rd_addr_b = (status_next == utli_pkg::ST_INTERP) ? addr_a + AW'(1) : addr_a;
  end

  logic [VW-1:0] y0_raw, y1_raw;

  utli_table u_table (
    .clk     (clk),
    .req     (req),
    .rdata_a (y0_raw),
    .rdata_b (y1_raw)
  );

  // stage 4: table data, fraction
  logic              s4_valid;
  utli_pkg::status_t s4_status;
  logic [FW-1:0]     s4_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid && s3_query;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_status <= status_next;
      s4_frac   <= (status_next == utli_pkg::ST_INTERP) ? frac : '0;
    end
  end

  // stage 5: slope times fraction
  logic signed [DIFF_W-1:0] slope;
  logic signed [FW:0]       frac_s;
  logic signed [PROD_W-1:0] prod_next;

  assign slope     = {y1_raw[VW-1], y1_raw} - {y0_raw[VW-1], y0_raw};
  assign frac_s    = {1'b0, s4_frac};
  assign prod_next = slope * frac_s;

  logic                     s5_valid;
  utli_pkg::status_t        s5_status;
  logic [VW-1:0]            s5_y0;
  logic signed [PROD_W-1:0] s5_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (advance) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_status <= s4_status;
      s5_y0     <= y0_raw;
      s5_prod   <= prod_next;
    end
  end

  // output register; arithmetic shift of the product gives the floor
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_value <= s5_y0 + s5_prod[FW +: VW];
      clamp_status <= s5_status;
    end
  end

`ifndef SYNTH
  a_clamp_zero_frac: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && s4_status != utli_pkg::ST_INTERP) |-> (s4_frac == '0))
    else $error("non-interpolated query carries a nonzero fraction");

  a_adjacent_read: assert property (@(posedge clk) disable iff (rst)
    (req.rd_en && status_next == utli_pkg::ST_INTERP) |->
      (req.rd_addr_b == req.rd_addr_a + AW'(1) && req.rd_addr_a < last_idx))
    else $error("interpolation reads a non-adjacent or out-of-range segment");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(s5_prod) && $stable(s5_y0) && $stable(s5_valid)))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

### src/utli_table.sv
// Sample table: one write port, two registered read ports.
`timescale 1ns / 1ps

module utli_table (
  input  logic                              clk,
  input  utli_pkg::table_req_t              req,
  output logic [utli_pkg::VALUE_W-1:0]      rdata_a,
  output logic [utli_pkg::VALUE_W-1:0]      rdata_b
);

  logic [utli_pkg::VALUE_W-1:0] mem [utli_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_a <= mem[req.rd_addr_a];
      rdata_b <= mem[req.rd_addr_b];
    end
  end

endmodule
